### rtl/core/assert_macros.svh
// Assertion helpers shared by the core RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property must hold on every clock outside reset.
`define ASSERT_CHK(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");
// Condition must never be seen on a clock outside reset.
`define ASSERT_NEVER(label, cond) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_CHK(label, prop)
`define ASSERT_NEVER(label, cond)
`endif
`endif

### rtl/core/pmm_pkg.sv
package pmm_pkg;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_ITER,
    S_WRITE,
    S_OUT
  } state_e;

  // Microprogram steps, in execution order
  typedef enum logic [4:0] {
    P_DEN, P_WCDD, P_Z, P_Z2, P_T1, P_A1, P_A2, P_JNUM, P_J,
    P_J2, P_J3, P_J4,
    P_CT1, P_CT2, P_CT3, P_CT4,
    P_CP1, P_CP2, P_CP3, P_CP4,
    P_THR, P_MAG, P_EMFN, P_EMF, P_CURN, P_CUR, P_TQN, P_TQ, P_TQS
  } step_e;

  // Input item kinds
  typedef enum logic [1:0] {
    FUNC_SAMPLE,
    FUNC_RAISE,
    FUNC_LOWER,
    FUNC_KEY
  } func_e;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_CT_LOW,
    REG_CP_LOW,
    REG_QUARTIC,
    REG_DIAM,
    REG_KV,
    REG_I0R0,
    REG_BATT,
    REG_VSTEP
  } reg_e;

  // Shared unit geometry
  localparam int MUL_A_W  = 52;
  localparam int MUL_B_W  = 36;
  localparam int PROD_W   = MUL_A_W + MUL_B_W;
  localparam int DIV_N_W  = 48;
  localparam int DIV_D_W  = 32;
  localparam logic [5:0] MUL_LAST = 6'd8;   // nine radix-16 digits
  localparam logic [5:0] DIV_LAST = 6'd47;  // one quotient bit per cycle

  // Scale factors
  localparam logic [35:0] J_SCALE      = 36'd1037542885;
  localparam logic [35:0] Z_SCALE      = 36'd4860908570;
  localparam logic [35:0] THRUST_SCALE = 36'd44610080259;
  localparam logic [35:0] AERO_SCALE   = 36'd704435623;
  localparam logic [35:0] BEMF_SCALE   = 36'd9778480;
  localparam logic [35:0] TQ_SCALE     = 36'd41013916;
  localparam logic [35:0] MA_SCALE     = 36'd1000;
  localparam logic [35:0] TQS_SCALE    = 36'd15625;

  // Limits
  localparam logic [15:0] RPS_MIN    = 16'd41;
  localparam logic [15:0] WC_MAX     = 16'd64000;
  localparam logic [16:0] J_ONE      = 17'd65536;
  localparam logic [16:0] TQ_ONE     = 17'd65536;
  localparam logic [13:0] THRUST_MAX = 14'd10000;
  localparam logic [14:0] CUR_MAX    = 15'd20000;

  // Floor a Q.16 accumulator to Q2.14 and saturate to 16 bits
  function automatic logic signed [15:0] sat_q14(input logic signed [35:0] acc);
    logic signed [35:0] sh;
    sh = acc >>> 16;
    if (sh > 36'sd32767) begin
      return 16'sh7FFF;
    end else if (sh < -36'sd32768) begin
      return 16'sh8000;
    end
    return sh[15:0];
  endfunction

  // Magnitude of a signed 16-bit coefficient
  function automatic logic [15:0] mag16(input logic [15:0] c);
    return c[15] ? 16'(~c + 16'd1) : c;
  endfunction

endpackage

### rtl/core/propeller_motor_model_top.sv
// Motor and propeller model.
// Input stream (s_axis_*): tuser carries the item kind (sample, raise,
// lower, clamp-only key); tdata carries airspeed and shaft rate.
// Output stream (m_axis_*): one result word per input word, all nine
// fields packed into tdata.
// Config channel (cfg_*): always ready; write only while the block idles.
// A throttle word updates the stored motor voltage; its result passes
// through the S_OUT state into the output register. A sample word runs a
// 29-step microprogram on one shared radix-16 shift-add multiplier and
// one restoring divider: 25 products and 4 quotients give the result.
// One word is worked at a time; s_axis_tready is high only while idle,
// so a new word can be taken in the cycle after a result is loaded into
// the output register.
// The result sits in an output register: a stalled receiver holds it and
// the next word may be accepted and worked meanwhile; the sequencer waits
// at the end only if the older result is still not taken.
// Reset sets motor voltage to zero, kv to 1000, resistance to 1 milliohm
// and clears the other configuration registers and any pending result.
`include "assert_macros.svh"
module propeller_motor_model_top import pmm_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // [15:0] axial_speed, [32:16] shaft_rate, [39:33] zero
  input  logic [39:0]  s_axis_tdata,
  // [1:0] func
  input  logic [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [16:0] advance_ratio, [32:17] thrust_coeff, [48:33] power_coeff,
  // [62:49] thrust, [86:63] prop_torque, [101:87] motor_current,
  // [118:102] motor_torque, [142:119] net_torque, [158:143] motor_voltage,
  // [159] zero
  output logic [159:0] m_axis_tdata,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [2:0]   cfg_index_i,
  input  logic [63:0]  cfg_data_i
);

  state_e state_q, state_d;
  step_e  step_q;
  logic [5:0] cnt_q;

  // Configuration
  logic [63:0] ct_low_q, cp_low_q;
  logic [31:0] quartic_q, i0r0_q;
  logic [15:0] dia_q, kv_q, batt_q, vstep_q, volt_q;

  // Item
  logic              thr_item_q;
  logic [15:0]       wc_q;
  logic signed [15:0] vsp_q;

  // Shared unit
  logic [MUL_A_W-1:0] ma_q;
  logic [PROD_W-1:0]  mp_q;
  logic [DIV_D_W-1:0] dr_q, dd_q;
  logic [DIV_N_W-1:0] dq_q;

  // Intermediates
  logic [31:0] den_q;
  logic [47:0] wcdd_q;
  logic [32:0] z_q;
  logic [48:0] z2_q;
  logic [51:0] t1_q;
  logic [45:0] a1_q, a2_q;
  logic [44:0] jnum_q;
  logic [16:0] j_q, j2_q, j3_q, j4_q;
  logic signed [35:0] acc_ct_q, acc_cp_q;
  logic [13:0] thr_q;
  logic [23:0] aero_q;
  logic [39:0] emfn_q;
  logic [40:0] emf_q;
  logic [41:0] curn_q;
  logic [14:0] cur_q;
  logic [40:0] tqn_q;
  logic [16:0] tq_q;
  logic [19:0] tqs_q;

  logic         m_valid_q;
  logic [159:0] m_data_q;

  logic accept, out_free;
  assign accept      = s_axis_tvalid && s_axis_tready;
  assign out_free    = !m_valid_q || m_axis_tready;
  assign cfg_ready_o = 1'b1;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  // Clamp incoming shaft rate
  logic [16:0] rate_in;
  logic [15:0] wc_in;
  always_comb begin
    rate_in = s_axis_tdata[32:16];
    if (rate_in[16]) begin
      wc_in = '0;
    end else if (rate_in[15:0] > WC_MAX) begin
      wc_in = WC_MAX;
    end else begin
      wc_in = rate_in[15:0];
    end
  end

  // Throttle voltage update
  logic [16:0] volt_sum, volt_cand;
  logic [15:0] volt_new;
  always_comb begin
    volt_sum = {1'b0, volt_q} + {1'b0, vstep_q};
    case (func_e'(s_axis_tuser))
      FUNC_RAISE: volt_cand = volt_sum;
      FUNC_LOWER: volt_cand = (volt_q > vstep_q) ? {1'b0, volt_q - vstep_q} : '0;
      default:    volt_cand = {1'b0, volt_q};
    endcase
    volt_new = (volt_cand > {1'b0, batt_q}) ? batt_q : volt_cand[15:0];
  end

  // Derived operands
  logic [31:0] vq;
  logic [15:0] r0, i0;
  logic        emf_below, cur_above;
  logic [14:0] cur_less_i0;
  logic signed [15:0] ct_w, cp_w;
  assign vq          = {volt_q, 16'b0};
  assign r0          = (i0r0_q[15:0] == 16'd0) ? 16'd1 : i0r0_q[15:0];
  assign i0          = i0r0_q[31:16];
  assign emf_below   = {9'b0, vq} > emf_q;
  assign cur_above   = {1'b0, cur_q} > i0;
  assign cur_less_i0 = cur_q - i0[14:0];
  assign ct_w        = sat_q14(acc_ct_q);
  assign cp_w        = sat_q14(acc_cp_q);

  // Microprogram: operands of the shared unit per step
  logic               is_div;
  logic [MUL_A_W-1:0] op_a;
  logic [MUL_B_W-1:0] op_b;
  logic [DIV_N_W-1:0] dv_n;
  logic [DIV_D_W-1:0] dv_d;
  logic [15:0]        coef;
  always_comb begin
    is_div = 1'b0;
    op_a   = '0;
    op_b   = '0;
    dv_n   = '0;
    dv_d   = '0;
    coef   = '0;
    unique case (step_q)
      P_DEN:  begin op_a = 52'(wc_q);   op_b = 36'(dia_q); end
      P_WCDD: begin op_a = 52'(den_q);  op_b = 36'(dia_q); end
      P_Z:    begin op_a = 52'(wcdd_q); op_b = Z_SCALE; end
      P_Z2:   begin op_a = 52'(z_q);    op_b = 36'(z_q); end
      P_T1:   begin op_a = 52'(z2_q);   op_b = THRUST_SCALE; end
      P_A1:   begin op_a = 52'(z2_q);   op_b = AERO_SCALE; end
      P_A2:   begin op_a = 52'(a1_q);   op_b = 36'(dia_q); end
      P_JNUM: begin
        op_a = 52'(J_SCALE);
        op_b = vsp_q[15] ? '0 : 36'(vsp_q[14:0]);
      end
      P_J:    begin is_div = 1'b1; dv_n = 48'(jnum_q); dv_d = den_q; end
      P_J2:   begin op_a = 52'(j_q);  op_b = 36'(j_q); end
      P_J3:   begin op_a = 52'(j2_q); op_b = 36'(j_q); end
      P_J4:   begin op_a = 52'(j3_q); op_b = 36'(j_q); end
      P_CT1:  begin coef = ct_low_q[31:16]; op_a = 52'(j_q);  op_b = 36'(mag16(coef)); end
      P_CT2:  begin coef = ct_low_q[47:32]; op_a = 52'(j2_q); op_b = 36'(mag16(coef)); end
      P_CT3:  begin coef = ct_low_q[63:48]; op_a = 52'(j3_q); op_b = 36'(mag16(coef)); end
      P_CT4:  begin coef = quartic_q[15:0]; op_a = 52'(j4_q); op_b = 36'(mag16(coef)); end
      P_CP1:  begin coef = cp_low_q[31:16]; op_a = 52'(j_q);  op_b = 36'(mag16(coef)); end
      P_CP2:  begin coef = cp_low_q[47:32]; op_a = 52'(j2_q); op_b = 36'(mag16(coef)); end
      P_CP3:  begin coef = cp_low_q[63:48]; op_a = 52'(j3_q); op_b = 36'(mag16(coef)); end
      P_CP4:  begin coef = quartic_q[31:16]; op_a = 52'(j4_q); op_b = 36'(mag16(coef)); end
      P_THR:  begin
        op_a = t1_q;
        op_b = (ct_w > 16'sd0) ? 36'(ct_w[14:0]) : '0;
      end
      P_MAG:  begin op_a = 52'(a2_q); op_b = 36'(mag16(cp_w)); end
      P_EMFN: begin op_a = 52'(BEMF_SCALE); op_b = 36'(wc_q); end
      P_EMF:  begin is_div = 1'b1; dv_n = 48'(emfn_q); dv_d = 32'(kv_q); end
      P_CURN: begin op_a = 52'(vq - emf_q[31:0]); op_b = MA_SCALE; end
      P_CUR:  begin is_div = 1'b1; dv_n = 48'(curn_q); dv_d = {r0, 16'b0}; end
      P_TQN:  begin op_a = 52'(TQ_SCALE); op_b = 36'(cur_less_i0); end
      P_TQ:   begin is_div = 1'b1; dv_n = 48'(tqn_q); dv_d = {kv_q, 16'b0}; end
      P_TQS:  begin op_a = 52'(tq_q); op_b = TQS_SCALE; end
      default: begin end
    endcase
  end

  // Shared unit datapath: one radix-16 digit or one quotient bit per cycle
  logic [55:0] mul_part, mul_sum;
  logic [32:0] div_t, div_diff;
  logic        div_ge;
  assign mul_part = 56'(ma_q) * 56'(mp_q[3:0]);
  assign mul_sum  = 56'(mp_q[PROD_W-1:MUL_B_W]) + mul_part;
  assign div_t    = {dr_q, dq_q[DIV_N_W-1]};
  assign div_ge   = div_t >= {1'b0, dd_q};
  assign div_diff = div_t - {1'b0, dd_q};

  // Signed polynomial term
  logic signed [35:0] term_w;
  logic [35:0]        prod_t;
  logic [46:0]        mag_w;
  assign prod_t = {3'b0, mp_q[32:0]};
  assign term_w = coef[15] ? -$signed(prod_t) : $signed(prod_t);
  assign mag_w  = mp_q[60:14];

  // Sequencer next state and ready
  always_comb begin
    state_d       = state_q;
    s_axis_tready = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          state_d = (func_e'(s_axis_tuser) == FUNC_SAMPLE) ? S_START : S_OUT;
        end
      end
      S_START: state_d = S_ITER;
      S_ITER:  if (cnt_q == 6'd0) state_d = S_WRITE;
      S_WRITE: state_d = (step_q == P_TQS) ? S_OUT : S_START;
      S_OUT:   if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Control counters and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q    <= P_DEN;
      cnt_q     <= '0;
      m_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        step_q <= P_DEN;
      end else if (state_q == S_WRITE && step_q != P_TQS) begin
        step_q <= step_e'(step_q + 5'd1);
      end
      if (state_q == S_START) begin
        cnt_q <= is_div ? DIV_LAST : MUL_LAST;
      end else if (state_q == S_ITER) begin
        cnt_q <= cnt_q - 6'd1;
      end
      if (state_q == S_OUT && out_free) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // Configuration registers and motor voltage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ct_low_q  <= '0;
      cp_low_q  <= '0;
      quartic_q <= '0;
      dia_q     <= '0;
      kv_q      <= 16'd1000;
      i0r0_q    <= 32'd1;
      batt_q    <= '0;
      vstep_q   <= '0;
      volt_q    <= '0;
    end else begin
      if (cfg_valid_i) begin
        unique case (reg_e'(cfg_index_i))
          REG_CT_LOW:  ct_low_q  <= cfg_data_i;
          REG_CP_LOW:  cp_low_q  <= cfg_data_i;
          REG_QUARTIC: quartic_q <= cfg_data_i[31:0];
          REG_DIAM:    dia_q     <= cfg_data_i[15:0];
          REG_KV:      kv_q      <= cfg_data_i[15:0];
          REG_I0R0:    i0r0_q    <= cfg_data_i[31:0];
          REG_BATT:    batt_q    <= cfg_data_i[15:0];
          REG_VSTEP:   vstep_q   <= cfg_data_i[15:0];
          default: begin end
        endcase
      end
      if (accept && func_e'(s_axis_tuser) != FUNC_SAMPLE) begin
        volt_q <= volt_new;
      end
    end
  end

  // Result fields
  logic         spin;
  logic [23:0]  aero_g;
  logic signed [25:0] net_full;
  logic [23:0]  net_w;
  logic [159:0] res_data;
  always_comb begin
    spin     = wc_q >= RPS_MIN;
    aero_g   = spin ? aero_q : '0;
    net_full = $signed({6'b0, tqs_q}) - $signed({{2{aero_g[23]}}, aero_g});
    if (net_full > 26'sd8388607) begin
      net_w = 24'h7FFFFF;
    end else if (net_full < -26'sd8388608) begin
      net_w = 24'h800000;
    end else begin
      net_w = net_full[23:0];
    end
    if (thr_item_q) begin
      res_data = {1'b0, volt_q, 143'b0};
    end else begin
      res_data = {1'b0, volt_q, net_w, tq_q, cur_q, aero_g,
                  (spin && ct_w > 16'sd0) ? thr_q : 14'd0,
                  spin ? cp_w : 16'sd0,
                  spin ? ct_w : 16'sd0,
                  spin ? j_q : 17'd0};
    end
  end

  // Item capture, shared unit and step write-back
  always_ff @(posedge clk_i) begin
    if (state_q == S_OUT && out_free) begin
      m_data_q <= res_data;
    end
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          thr_item_q <= func_e'(s_axis_tuser) != FUNC_SAMPLE;
          wc_q       <= wc_in;
          vsp_q      <= s_axis_tdata[15:0];
          acc_ct_q   <= {{4{ct_low_q[15]}}, ct_low_q[15:0], 16'b0};
          acc_cp_q   <= {{4{cp_low_q[15]}}, cp_low_q[15:0], 16'b0};
        end
      end
      S_START: begin
        ma_q <= op_a;
        mp_q <= {52'b0, op_b};
        dr_q <= '0;
        dq_q <= dv_n;
        dd_q <= dv_d;
      end
      S_ITER: begin
        mp_q <= {mul_sum, mp_q[MUL_B_W-1:4]};
        dr_q <= div_ge ? div_diff[31:0] : div_t[31:0];
        dq_q <= {dq_q[DIV_N_W-2:0], div_ge};
      end
      S_WRITE: begin
        case (step_q)
          P_DEN:  den_q  <= mp_q[31:0];
          P_WCDD: wcdd_q <= mp_q[47:0];
          P_Z:    z_q    <= mp_q[80:48];
          P_Z2:   z2_q   <= mp_q[64:16];
          P_T1:   t1_q   <= mp_q[83:32];
          P_A1:   a1_q   <= mp_q[77:32];
          P_A2:   a2_q   <= mp_q[61:16];
          P_JNUM: jnum_q <= mp_q[44:0];
          P_J: begin
            if (vsp_q[15] || vsp_q == 16'sd0) begin
              j_q <= '0;
            end else if (den_q == 32'd0 || dq_q > 48'(J_ONE)) begin
              j_q <= J_ONE;
            end else begin
              j_q <= dq_q[16:0];
            end
          end
          P_J2: j2_q <= mp_q[32:16];
          P_J3: j3_q <= mp_q[32:16];
          P_J4: j4_q <= mp_q[32:16];
          P_CT1, P_CT2, P_CT3, P_CT4: acc_ct_q <= acc_ct_q + term_w;
          P_CP1, P_CP2, P_CP3, P_CP4: acc_cp_q <= acc_cp_q + term_w;
          P_THR: begin
            thr_q <= (mp_q[87:30] > 58'd10000) ? THRUST_MAX : mp_q[43:30];
          end
          P_MAG: begin
            if (cp_w < 16'sd0) begin
              aero_q <= (mag_w >= 47'd8388608) ? 24'h800000 : 24'(~mag_w[23:0] + 24'd1);
            end else begin
              aero_q <= (mag_w > 47'd8388607) ? 24'h7FFFFF : mag_w[23:0];
            end
          end
          P_EMFN: emfn_q <= mp_q[39:0];
          P_EMF: begin
            if (kv_q == 16'd0) begin
              emf_q <= (wc_q != 16'd0) ? '1 : '0;
            end else begin
              emf_q <= {1'b0, dq_q[39:0]};
            end
          end
          P_CURN: curn_q <= mp_q[41:0];
          P_CUR: begin
            if (!emf_below) begin
              cur_q <= '0;
            end else if (dq_q > 48'(CUR_MAX)) begin
              cur_q <= CUR_MAX;
            end else begin
              cur_q <= dq_q[14:0];
            end
          end
          P_TQN: tqn_q <= mp_q[40:0];
          P_TQ: begin
            if (!cur_above) begin
              tq_q <= '0;
            end else if (kv_q == 16'd0 || dq_q > 48'(TQ_ONE)) begin
              tq_q <= TQ_ONE;
            end else begin
              tq_q <= dq_q[16:0];
            end
          end
          P_TQS: tqs_q <= mp_q[29:10];
          default: begin end
        endcase
      end
      default: begin end
    endcase
  end

  // Checks
  `ASSERT_CHK(a_busy_after_accept, (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
  `ASSERT_CHK(a_volt_clamped, (state_q == S_OUT && thr_item_q) |-> (volt_q <= batt_q))
  `ASSERT_CHK(a_cnt_bound, (state_q == S_ITER) |-> (cnt_q <= DIV_LAST))
  `ASSERT_NEVER(a_stray_result, $rose(m_axis_tvalid) && !$past(state_q == S_OUT))

endmodule

### sim/tb_propeller_motor_model_top.sv
module tb_propeller_motor_model_top import pmm_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [63:0] K_J      = 64'd1037542885;
  localparam logic [63:0] K_Z      = 64'd4860908570;
  localparam logic [63:0] K_THRUST = 64'd44610080259;
  localparam logic [63:0] K_AERO   = 64'd704435623;
  localparam logic [63:0] K_BEMF   = 64'd9778480;
  localparam logic [63:0] K_TQ     = 64'd41013916;
  localparam logic [63:0] PROD_CAP = 64'h4000_0000_0000_0000;
  localparam longint      TQ_POS   = 8388607;
  localparam longint      TQ_NEG   = -8388608;

  typedef struct {
    logic [1:0]  func;
    logic [15:0] speed;
    logic [16:0] rate;
  } stim_t;

  typedef struct {
    longint adv;
    longint ct;
    longint cp;
    longint thrust;
    longint aero;
    longint cur;
    longint tq;
    longint net;
    longint volt;
  } motor_out_t;

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [39:0]  s_axis_tdata;
  logic [1:0]   s_axis_tuser;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [159:0] m_axis_tdata;
  logic         cfg_valid_i;
  logic         cfg_ready_o;
  logic [2:0]   cfg_index_i;
  logic [63:0]  cfg_data_i;

  // Shadow copy of the register file and the stored voltage
  logic [63:0] ct_low, cp_low, quartic, diam, kv, i0r0, batt, vstep;
  logic [63:0] volt_now;

  stim_t      item_q[$];
  motor_out_t expect_q[$];
  int         errors;
  bit         calm;

  propeller_motor_model_top DUT (.*);

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #60_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // floor(a*b / 2^s), saturated
  function automatic logic [63:0] mul_shift(logic [63:0] a, logic [63:0] b, int s);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    p = p >> s;
    if (p > {64'd0, PROD_CAP}) return PROD_CAP;
    return p[63:0];
  endfunction

  function automatic longint eval_quartic(logic [63:0] low4, logic [15:0] c4, logic [63:0] j);
    logic [63:0] j2, j3, j4;
    longint acc, q;
    j2 = (j * j) >> 16;
    j3 = (j2 * j) >> 16;
    j4 = (j3 * j) >> 16;
    acc = longint'($signed(low4[15:0])) * 65536
        + longint'($signed(low4[31:16])) * longint'(j)
        + longint'($signed(low4[47:32])) * longint'(j2)
        + longint'($signed(low4[63:48])) * longint'(j3)
        + longint'($signed(c4)) * longint'(j4);
    q = acc >= 0 ? acc / 65536 : -((-acc + 65535) / 65536);
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return q;
  endfunction

  // Work out the result of one word and advance the stored voltage
  function automatic motor_out_t motor_predict(stim_t it);
    motor_out_t o;
    longint w, spd;
    logic [63:0] wc, den, j, z, z2, a2, mag, r0, i0, vq, emf, cur, tq, cpm;
    o = '{default: 0};
    if (it.func != FUNC_SAMPLE) begin
      if (it.func == FUNC_RAISE) volt_now = volt_now + vstep;
      else if (it.func == FUNC_LOWER) volt_now = volt_now > vstep ? volt_now - vstep : 0;
      if (volt_now > batt) volt_now = batt;
      o.volt = longint'(volt_now);
      return o;
    end
    spd = longint'($signed(it.speed));
    w = longint'($signed(it.rate));
    wc = w < 0 ? 0 : (w > 64000 ? 64000 : w);
    j = 0;
    if (wc >= 41) begin
      den = wc * diam;
      if (spd <= 0) j = 0;
      else if (den == 0) j = 65536;
      else begin
        j = (spd * K_J) / den;
        if (j > 65536) j = 65536;
      end
      o.ct = eval_quartic(ct_low, quartic[15:0], j);
      o.cp = eval_quartic(cp_low, quartic[31:16], j);
      z = mul_shift(wc * diam * diam, K_Z, 48);
      z2 = mul_shift(z, z, 16);
      if (o.ct > 0) begin
        o.thrust = longint'(mul_shift(mul_shift(z2, K_THRUST, 32), o.ct, 30));
        if (o.thrust > 10000) o.thrust = 10000;
      end
      a2 = mul_shift(mul_shift(z2, K_AERO, 32), diam, 16);
      cpm = o.cp < 0 ? -o.cp : o.cp;
      mag = mul_shift(a2, cpm, 14);
      if (o.cp < 0) o.aero = mag > 8388608 ? TQ_NEG : -longint'(mag);
      else o.aero = mag > 8388607 ? TQ_POS : longint'(mag);
    end
    o.adv = longint'(j);
    r0 = i0r0[15:0];
    if (r0 == 0) r0 = 1;
    i0 = i0r0[31:16];
    vq = volt_now << 16;
    cur = 0;
    tq = 0;
    if (kv == 0) emf = wc != 0 ? 64'hFFFF_FFFF_FFFF_FFFF : 0;
    else emf = (wc * K_BEMF) / kv;
    if (vq > emf) begin
      cur = ((vq - emf) * 1000) / (r0 << 16);
      if (cur > 20000) cur = 20000;
    end
    if (cur > i0) begin
      if (kv == 0) tq = 65536;
      else begin
        tq = ((cur - i0) * K_TQ) / (kv << 16);
        if (tq > 65536) tq = 65536;
      end
    end
    o.cur = longint'(cur);
    o.tq = longint'(tq);
    o.net = longint'((tq * 15625) / 1024) - o.aero;
    if (o.net > TQ_POS) o.net = TQ_POS;
    if (o.net < TQ_NEG) o.net = TQ_NEG;
    o.volt = longint'(volt_now);
    return o;
  endfunction

  // Present queued words to the input stream
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= '0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (item_q.size() > 0 && (calm || $urandom_range(99) >= 27)) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'd0, item_q[0].rate, item_q[0].speed};
        s_axis_tuser  <= item_q[0].func;
        void'(item_q.pop_front());
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Stall the output stream at random outside the calm phase
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) m_axis_tready <= 1'b0;
    else m_axis_tready <= calm || $urandom_range(99) >= 27;
  end

  task automatic check_field(string name, longint want, longint got);
    if (want != got) begin
      errors++;
      if (errors <= 10)
        $display("mismatch %s: expected %0d, got %0d", name, want, got);
    end
  endtask

  // Track config writes, predict accepted words, check results
  always @(posedge clk_i) begin
    motor_out_t e;
    stim_t it;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (reg_e'(cfg_index_i))
          REG_CT_LOW:  ct_low  = cfg_data_i;
          REG_CP_LOW:  cp_low  = cfg_data_i;
          REG_QUARTIC: quartic = cfg_data_i[31:0];
          REG_DIAM:    diam    = cfg_data_i[15:0];
          REG_KV:      kv      = cfg_data_i[15:0];
          REG_I0R0:    i0r0    = cfg_data_i[31:0];
          REG_BATT:    batt    = cfg_data_i[15:0];
          REG_VSTEP:   vstep   = cfg_data_i[15:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        it.func  = s_axis_tuser;
        it.speed = s_axis_tdata[15:0];
        it.rate  = s_axis_tdata[32:16];
        expect_q = {expect_q, motor_predict(it)};
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (expect_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result word %h", m_axis_tdata);
        end else begin
          e = expect_q.pop_front();
          check_field("advance_ratio", e.adv, longint'(m_axis_tdata[16:0]));
          check_field("thrust_coeff", e.ct, longint'($signed(m_axis_tdata[32:17])));
          check_field("power_coeff", e.cp, longint'($signed(m_axis_tdata[48:33])));
          check_field("thrust", e.thrust, longint'(m_axis_tdata[62:49]));
          check_field("prop_torque", e.aero, longint'($signed(m_axis_tdata[86:63])));
          check_field("motor_current", e.cur, longint'(m_axis_tdata[101:87]));
          check_field("motor_torque", e.tq, longint'(m_axis_tdata[118:102]));
          check_field("net_torque", e.net, longint'($signed(m_axis_tdata[142:119])));
          check_field("motor_voltage", e.volt, longint'(m_axis_tdata[158:143]));
        end
      end
    end
  end

  task automatic write_reg(reg_e idx, logic [63:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic load_regs(logic [63:0] ctl, logic [63:0] cpl, logic [31:0] q4,
                           logic [15:0] d, logic [15:0] k, logic [31:0] ir,
                           logic [15:0] b, logic [15:0] st);
    write_reg(REG_CT_LOW, ctl);
    write_reg(REG_CP_LOW, cpl);
    write_reg(REG_QUARTIC, {32'd0, q4});
    write_reg(REG_DIAM, {48'd0, d});
    write_reg(REG_KV, {48'd0, k});
    write_reg(REG_I0R0, {32'd0, ir});
    write_reg(REG_BATT, {48'd0, b});
    write_reg(REG_VSTEP, {48'd0, st});
  endtask

  // Hold until every queued word is taken and every result is back
  task automatic drain();
    do @(posedge clk_i);
    while (item_q.size() > 0 || s_axis_tvalid || expect_q.size() > 0);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic add_item(func_e f, int spd, int rate);
    stim_t it;
    it.func  = f;
    it.speed = 16'(spd);
    it.rate  = 17'(rate);
    item_q = {item_q, it};
  endtask

  function automatic logic [15:0] rand_coeff();
    return $urandom_range(3) == 0 ? 16'($urandom) : 16'($urandom_range(4000) - 2000);
  endfunction

  task automatic add_random_items(int n);
    stim_t it;
    int pick;
    repeat (n) begin
      pick = $urandom_range(99);
      it.func = pick < 70 ? FUNC_SAMPLE : 2'($urandom_range(3));
      case ($urandom_range(3))
        0: it.speed = 16'($urandom);
        1: it.speed = 16'($urandom_range(6400));
        default: it.speed = 16'($urandom_range(2560));
      endcase
      case ($urandom_range(5))
        0: it.rate = 17'($urandom);
        1: it.rate = 17'($urandom_range(45, 36));
        2: it.rate = 17'($urandom_range(64001, 63990));
        default: it.rate = 17'($urandom_range(64000));
      endcase
      item_q = {item_q, it};
    end
  endtask

  initial begin
    errors = 0;
    calm = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    rst_ni = 1'b0;
    ct_low = 0; cp_low = 0; quartic = 0; diam = 0;
    kv = 1000; i0r0 = 1; batt = 0; vstep = 0; volt_now = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset values: throttle has no effect, motor part only
    add_item(FUNC_RAISE, 0, 0);
    add_item(FUNC_SAMPLE, 256, 6400);
    drain();

    // Typical prop and motor, directed corners
    load_regs({16'd200, 16'h3f00, 16'hf800, 16'd1600},
              {16'hfc00, 16'd300, 16'd500, 16'd700},
              {16'd100, 16'hff00}, 16'd2560, 16'd1000, {16'd500, 16'd100},
              16'd12000, 16'd5000);
    add_item(FUNC_RAISE, 0, 0);
    add_item(FUNC_RAISE, 0, 0);
    add_item(FUNC_RAISE, 0, 0);
    add_item(FUNC_SAMPLE, 32767, 64000);
    add_item(FUNC_SAMPLE, -32768, 64000);
    add_item(FUNC_SAMPLE, 0, 6400);
    add_item(FUNC_SAMPLE, 1, 41);
    add_item(FUNC_SAMPLE, 1280, 40);
    add_item(FUNC_SAMPLE, 1280, 64001);
    add_item(FUNC_SAMPLE, 1280, 65535);
    add_item(FUNC_SAMPLE, 1280, -1);
    add_item(FUNC_SAMPLE, 1280, -65536);
    add_item(FUNC_SAMPLE, 32767, 41);
    add_item(FUNC_KEY, 0, 0);
    add_item(FUNC_LOWER, 0, 0);
    add_item(FUNC_LOWER, 0, 0);
    add_item(FUNC_LOWER, 0, 0);
    add_item(FUNC_SAMPLE, 640, 3200);
    drain();

    // Lowered battery while the voltage is zero: samples and a key keep it
    write_reg(REG_BATT, 64'd3000);
    add_item(FUNC_SAMPLE, 640, 3200);
    add_item(FUNC_KEY, -1, 131071);
    add_item(FUNC_SAMPLE, 640, 3200);
    drain();

    // Zero diameter, kv and resistance
    load_regs(64'h7fff_7fff_7fff_7fff, 64'h8000_8000_8000_8000, 32'h8000_7fff,
              16'd0, 16'd0, 32'hffff_0000, 16'hffff, 16'd1000);
    add_item(FUNC_RAISE, 0, 0);
    add_item(FUNC_SAMPLE, 100, 0);
    add_item(FUNC_SAMPLE, 100, 41);
    add_item(FUNC_SAMPLE, -100, 41);
    add_item(FUNC_SAMPLE, 0, 64000);
    drain();

    // Largest values everywhere
    load_regs('1, '1, '1, 16'hffff, 16'hffff, 32'hffff_ffff, 16'hffff, 16'hffff);
    add_item(FUNC_RAISE, 0, 0);
    add_item(FUNC_RAISE, 0, 0);
    add_item(FUNC_SAMPLE, 32767, 64000);
    add_item(FUNC_SAMPLE, 1, 41);
    add_item(FUNC_LOWER, 0, 0);
    add_item(FUNC_LOWER, 0, 0);
    drain();

    // Random settings, one phase without any idling
    for (int ph = 0; ph < 9; ph++) begin
      calm = (ph == 4);
      load_regs({rand_coeff(), rand_coeff(), rand_coeff(), rand_coeff()},
                {rand_coeff(), rand_coeff(), rand_coeff(), rand_coeff()},
                {rand_coeff(), rand_coeff()},
                $urandom_range(7) == 0 ? 16'($urandom) : 16'($urandom_range(5120, 1024)),
                $urandom_range(7) == 0 ? 16'($urandom) : 16'($urandom_range(3000, 300)),
                $urandom_range(7) == 0 ? $urandom :
                  {16'($urandom_range(2000)), 16'($urandom_range(500, 20))},
                $urandom_range(7) == 0 ? 16'($urandom) : 16'($urandom_range(25000, 6000)),
                16'($urandom_range(4000)));
      add_random_items(220);
      drain();
    end
    calm = 1'b0;

    repeat (20) @(posedge clk_i);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+rtl/core
rtl/core/pmm_pkg.sv
rtl/core/propeller_motor_model_top.sv
sim/tb_propeller_motor_model_top.sv
